>>> sv/swmf_pkg.sv
package swmf_pkg;

    // payload widths
    localparam int PIX_W   = 8;
    localparam int COORD_W = 11;
    localparam int SIZE_W  = 12;

    // stream data widths
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 32;

    // register port
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    // register reset values and size limit
    localparam logic [SIZE_W-1:0] WIDTH_RESET  = 12'd640;
    localparam logic [SIZE_W-1:0] HEIGHT_RESET = 12'd480;
    localparam logic [SIZE_W-1:0] COUNT_LIMIT  = 12'd2048;

    // register index, taken from paddr bit 2
    typedef enum logic {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } swmf_reg_t;

endpackage

>>> sv/swmf_median.sv
module swmf_median
    import swmf_pkg::*;
#(
    parameter int WINDOW = 3
)
(
    input  logic [PIX_W-1:0] win [WINDOW*WINDOW],
    output logic [PIX_W-1:0] median
);

    localparam int N   = WINDOW * WINDOW;
    localparam int MID = (N - 1) / 2;
    localparam int RW  = $clog2(N);

    logic [N-1:0]    below [N];
    logic [RW-1:0]   rank  [N];
    logic [PIX_W-1:0] pick [N];

    // stable rank of every element: smaller values, or equal values further left
    always_comb
    begin
        for (int i = 0; i < N; i++)
        begin
            for (int j = 0; j < N; j++)
            begin
                if (j < i)
                    below[i][j] = (win[j] <= win[i]);
                else if (j > i)
                    below[i][j] = (win[j] < win[i]);
                else
                    below[i][j] = 1'b0;
            end
            rank[i] = RW'($countones(below[i]));
        end
    end

    // exactly one element holds the middle rank
    always_comb
    begin
        median = '0;
        for (int i = 0; i < N; i++)
        begin
            pick[i] = (rank[i] == RW'(MID)) ? win[i] : '0;
            median  = median | pick[i];
        end
    end

endmodule

>>> sv/sliding_window_median_filter_unit.sv
// Streaming WINDOW x WINDOW median filter for 8-bit grey pixels.
// Input stream (s_*): one pixel per request in raster order, row by row.
// Output stream (m_*): one request per interior pixel, i.e. when the pixel
// at row r, column c arrives with r and c both at least WINDOW-1. It carries
// the median of the window and the row and column of the window centre;
// m_tlast marks the interior result that ends the frame. Border pixels are
// not sent; the receiver fills them with zero.
// Register port: image_width at 0x0, image_height at 0x4 (12 bits each,
// clamped to 1..2048, the width also to MAX_WIDTH). A write restarts the frame.
// A result passes the stage 1, stage 2 and output registers once its pixel is
// accepted. Throughput: one pixel per cycle unless the output stalls, set by one
// line memory (one read, one write per cycle, forwarded when both hit one column).
// Reset empties the pipeline and restores the register defaults; the line
// memory needs no clearing since stale words only reach windows that are not sent.
// When the receiver stalls, the pipeline keeps taking pixels until a second
// result would have to enter the output register; s_tready then drops until
// the waiting result is taken.
module sliding_window_median_filter_unit
    import swmf_pkg::*;
#(
    parameter int WINDOW    = 3,
    parameter int MAX_WIDTH = 2048
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // register port
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [APB_AW-1:0]      paddr,
    input  logic [APB_DW-1:0]      pwdata,
    output logic [APB_DW-1:0]      prdata,
    output logic                   pready,
    // pixel input
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // [7:0] pixel
    // result output
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // [7:0] median_value, [18:8] center_row,
                                              // [29:19] center_col, [31:30] zero
    output logic                   m_tlast    // frame_last
);

    localparam int N     = WINDOW * WINDOW;
    localparam int HALF  = (WINDOW - 1) / 2;
    localparam int LINES = WINDOW - 1;
    localparam int LW    = PIX_W * LINES;
    localparam int AW    = $clog2(MAX_WIDTH);
    localparam int WMAX  = (MAX_WIDTH < 2048) ? MAX_WIDTH : 2048;

    typedef struct packed {
        logic               emit;
        logic               last;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
    } meta_t;

    // registers
    logic [SIZE_W-1:0]  image_width_reg, image_height_reg;
    logic [COORD_W-1:0] row_count_reg, row_count_next;
    logic [COORD_W-1:0] col_count_reg, col_count_next;

    logic               s1_valid_reg;
    logic [PIX_W-1:0]   s1_px_reg;
    logic [AW-1:0]      s1_addr_reg;
    meta_t              s1_meta_reg;
    logic [LW-1:0]      rd_data_reg;
    logic               fwd_reg;
    logic [LW-1:0]      fwd_data_reg;

    logic [PIX_W-1:0]   win_reg [WINDOW][WINDOW];
    logic               s2_valid_reg;
    meta_t              s2_meta_reg;

    logic               out_valid_reg;
    logic [PIX_W-1:0]   out_median_reg;
    logic [COORD_W-1:0] out_row_reg;
    logic [COORD_W-1:0] out_col_reg;
    logic               out_last_reg;

    logic [LW-1:0]      line_mem [MAX_WIDTH];

    // combinational
    logic               cfg_we;
    logic               adv;
    logic               in_accept;
    logic               mem_we;
    logic [AW-1:0]      rd_addr;
    logic [SIZE_W-1:0]  w_eff, h_eff;
    logic               col_wrap, row_wrap;
    meta_t              meta_in;
    logic [LW-1:0]      line_old;
    logic [PIX_W-1:0]   column [WINDOW];
    logic [LW-1:0]      mem_wdata;
    logic [PIX_W-1:0]   win_flat [N];
    logic [PIX_W-1:0]   median;

    // register port
    assign pready = 1'b1;
    assign cfg_we = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= WIDTH_RESET;
            image_height_reg <= HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            case (swmf_reg_t'(paddr[2]))
                REG_IMAGE_WIDTH:  image_width_reg  <= pwdata[SIZE_W-1:0];
                REG_IMAGE_HEIGHT: image_height_reg <= pwdata[SIZE_W-1:0];
                default:          image_width_reg  <= image_width_reg;
            endcase
        end
    end

    always_comb
    begin
        case (swmf_reg_t'(paddr[2]))
            REG_IMAGE_WIDTH:  prdata = {{(APB_DW-SIZE_W){1'b0}}, image_width_reg};
            REG_IMAGE_HEIGHT: prdata = {{(APB_DW-SIZE_W){1'b0}}, image_height_reg};
            default:          prdata = '0;
        endcase
    end

    // effective frame size
    always_comb
    begin
        if (image_width_reg == '0)
            w_eff = SIZE_W'(1);
        else if (image_width_reg > SIZE_W'(WMAX))
            w_eff = SIZE_W'(WMAX);
        else
            w_eff = image_width_reg;

        if (image_height_reg == '0)
            h_eff = SIZE_W'(1);
        else if (image_height_reg > COUNT_LIMIT)
            h_eff = COUNT_LIMIT;
        else
            h_eff = image_height_reg;
    end

    // pipeline advance: blocked only when a second result would hit a full output
    assign adv       = !(out_valid_reg && !m_tready && s2_valid_reg && s2_meta_reg.emit);
    assign s_tready  = adv;
    assign in_accept = s_tvalid & adv;
    assign rd_addr   = AW'(col_count_reg);

    // raster counters and per-pixel tags
    always_comb
    begin
        col_wrap = ({1'b0, col_count_reg} + SIZE_W'(1)) >= w_eff;
        row_wrap = ({1'b0, row_count_reg} + SIZE_W'(1)) >= h_eff;

        meta_in.emit = (row_count_reg >= COORD_W'(WINDOW - 1)) &&
                       (col_count_reg >= COORD_W'(WINDOW - 1));
        meta_in.last = ({1'b0, row_count_reg} == h_eff - SIZE_W'(1)) &&
                       ({1'b0, col_count_reg} == w_eff - SIZE_W'(1));
        meta_in.row  = row_count_reg - COORD_W'(HALF);
        meta_in.col  = col_count_reg - COORD_W'(HALF);

        row_count_next = row_count_reg;
        col_count_next = col_count_reg;
        if (cfg_we)
        begin
            row_count_next = '0;
            col_count_next = '0;
        end
        else if (in_accept)
        begin
            if (col_wrap)
            begin
                col_count_next = '0;
                row_count_next = row_wrap ? '0 : row_count_reg + COORD_W'(1);
            end
            else
            begin
                col_count_next = col_count_reg + COORD_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg <= '0;
            col_count_reg <= '0;
        end
        else
        begin
            row_count_reg <= row_count_next;
            col_count_reg <= col_count_next;
        end
    end

    // new window column: stored lines (oldest first) and the incoming pixel
    assign line_old = fwd_reg ? fwd_data_reg : rd_data_reg;

    always_comb
    begin
        for (int k = 0; k < LINES; k++)
        begin
            column[k] = line_old[k*PIX_W +: PIX_W];
        end
        column[WINDOW-1] = s1_px_reg;
        for (int k = 0; k < LINES; k++)
        begin
            mem_wdata[k*PIX_W +: PIX_W] = column[k+1];
        end
    end

    assign mem_we = adv & s1_valid_reg;

    // line memory: read at accept, written back from stage 1 when the pipeline advances
    always_ff @(posedge clk)
    begin
        if (mem_we)
            line_mem[s1_addr_reg] <= mem_wdata;
        if (in_accept)
            rd_data_reg <= line_mem[rd_addr];
    end

    // forward a write that lands on the column being read in the same cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fwd_reg <= 1'b0;
        else if (in_accept)
            fwd_reg <= mem_we && (s1_addr_reg == rd_addr);
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
            fwd_data_reg <= mem_wdata;
    end

    // stage 1: pixel and memory read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (adv)
            s1_valid_reg <= in_accept;
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_px_reg   <= s_tdata[PIX_W-1:0];
            s1_addr_reg <= rd_addr;
            s1_meta_reg <= meta_in;
        end
    end

    // stage 2: window shift
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            for (int k = 0; k < WINDOW; k++)
            begin
                for (int x = 0; x < WINDOW; x++)
                begin
                    win_reg[k][x] <= '0;
                end
            end
        end
        else if (adv)
        begin
            s2_valid_reg <= s1_valid_reg;
            if (s1_valid_reg)
            begin
                for (int k = 0; k < WINDOW; k++)
                begin
                    for (int x = 0; x < WINDOW - 1; x++)
                    begin
                        win_reg[k][x] <= win_reg[k][x+1];
                    end
                    win_reg[k][WINDOW-1] <= column[k];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && s1_valid_reg)
            s2_meta_reg <= s1_meta_reg;
    end

    // median of the current window
    always_comb
    begin
        for (int k = 0; k < WINDOW; k++)
        begin
            for (int x = 0; x < WINDOW; x++)
            begin
                win_flat[k*WINDOW + x] = win_reg[k][x];
            end
        end
    end

    swmf_median #(
        .WINDOW (WINDOW)
    ) u_median (
        .win    (win_flat),
        .median (median)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv && s2_valid_reg && s2_meta_reg.emit)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (adv && s2_valid_reg && s2_meta_reg.emit)
        begin
            out_median_reg <= median;
            out_row_reg    <= s2_meta_reg.row;
            out_col_reg    <= s2_meta_reg.col;
            out_last_reg   <= s2_meta_reg.last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_TDATA_W - PIX_W - 2*COORD_W){1'b0}},
                       out_col_reg, out_row_reg, out_median_reg};
    assign m_tlast  = out_last_reg;

endmodule

>>> sv/swmf_checker.sv
module swmf_checker
    import swmf_pkg::*;
#(
    parameter int WINDOW = 3
)
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_tready,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata,
    input logic                   m_tlast
);

    localparam int HALF = (WINDOW - 1) / 2;

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // input backpressure only while a result is waiting
    a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without a waiting result");

    // every result is centred inside the interior
    a_center_inside: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[18:8] >= COORD_W'(HALF)) &&
                     (m_tdata[29:19] >= COORD_W'(HALF)))
        else $error("result centre on the border");

    // output comes out of reset empty
    a_reset_quiet: assert property (@(posedge clk)
        $rose(rst_n) |-> !m_tvalid)
        else $error("result right after reset");

endmodule

bind sliding_window_median_filter_unit swmf_checker #(.WINDOW(WINDOW)) u_swmf_checker (.*);
